// ===== rtl/skat_pkg.sv =====
`timescale 1ns / 1ps

package skat_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_FULL           = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND      = 2'd2;
    localparam logic [1:0] ST_KEYS_EXHAUSTED = 2'd3;

    typedef enum logic [1:0] {
        RS_ZERO  = 2'd0,
        RS_INS   = 2'd1,
        RS_FOUND = 2'd2
    } res_sel_t;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DISP    = 8'b0000_0010,
        S_INS_RD  = 8'b0000_0100,
        S_INS_CHK = 8'b0000_1000,
        S_SRCH    = 8'b0001_0000,
        S_CMP     = 8'b0010_0000,
        S_SHF_RD  = 8'b0100_0000,
        S_SHF_WR  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       rd_last;
        logic       rd_mid;
        logic       rd_next;
        logic       wr_ins;
        logic       ins_first;
        logic       wr_shift;
        logic       step;
        logic       dec_count;
        logic       set_res;
        logic [1:0] res_status;
        res_sel_t   res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       exhausted;
        logic       range_empty;
        logic       key_eq;
        logic       key_lt;
        logic       shift_more;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/skat_ram.sv =====
`timescale 1ns / 1ps

module skat_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/skat_ctrl.sv =====
`timescale 1ns / 1ps

module skat_ctrl import skat_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && stat.out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                priority if (stat.req == REQ_INSERT) begin
                    if (stat.full) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_FULL;
                        cmd.out_load   = 1'b1;
                        state_next     = S_IDLE;
                    end else if (stat.empty) begin
                        cmd.wr_ins    = 1'b1;
                        cmd.ins_first = 1'b1;
                        cmd.set_res   = 1'b1;
                        cmd.res_sel   = RS_INS;
                        state_next    = S_IDLE;
                        cmd.out_load  = 1'b1;
                    end else begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_INS_RD;
                    end
                end else if (stat.req == REQ_LOOKUP || stat.req == REQ_DELETE) begin
                    state_next = S_SRCH;
                end else begin
                    cmd.set_res  = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INS_RD: begin
                cmd.rd_last = 1'b1;
                state_next  = S_INS_CHK;
            end
            S_INS_CHK: begin
                cmd.set_res  = 1'b1;
                cmd.out_load = 1'b1;
                if (stat.exhausted) begin
                    cmd.res_status = ST_KEYS_EXHAUSTED;
                end else begin
                    cmd.wr_ins  = 1'b1;
                    cmd.res_sel = RS_INS;
                end
                state_next = S_IDLE;
            end
            S_SRCH: begin
                if (stat.range_empty) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    cmd.out_load   = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (stat.key_eq) begin
                    if (stat.req == REQ_LOOKUP) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_sel  = RS_FOUND;
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_SHF_RD;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SHF_RD: begin
                if (stat.shift_more) begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHF_WR;
                end else begin
                    cmd.dec_count = 1'b1;
                    cmd.set_res   = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SHF_WR: begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHF_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/skat_dp.sv =====
`timescale 1ns / 1ps

module skat_dp import skat_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_key,
    input  logic [1:0]  s_course_code,
    input  logic [1:0]  s_year_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_result_key,
    output logic [1:0]  m_result_course,
    output logic [1:0]  m_result_year,
    output logic [6:0]  m_fill_count,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = KEY_BITS + 4;

    logic [1:0]          req_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [1:0]          course_reg;
    logic [1:0]          year_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [AW-1:0]       mid_reg;

    logic [1:0]          res_status_reg;
    logic [15:0]         res_key_reg;
    logic [1:0]          res_course_reg;
    logic [1:0]          res_year_reg;

    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [15:0]         m_key_reg;
    logic [1:0]          m_course_reg;
    logic [1:0]          m_year_reg;
    logic [6:0]          m_fill_reg;

    logic [WW-1:0]       rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [KEY_BITS-1:0] nk;
    logic [CW:0]         range_sum;
    logic [AW-1:0]       mid_calc;
    logic [CW-1:0]       j_inc;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WW-1:0]       wdata;
    logic [AW-1:0]       raddr;

    assign rd_key    = rdata[WW-1:4];
    assign nk        = cmd.ins_first ? KEY_BITS'(1) : rd_key + KEY_BITS'(1);
    assign range_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = AW'(range_sum >> 1);
    assign j_inc     = CW'(mid_reg) + CW'(1);

    always_comb begin
        priority if (cmd.rd_last) begin
            raddr = AW'(count_reg - CW'(1));
        end else if (cmd.rd_next) begin
            raddr = AW'(j_inc);
        end else begin
            raddr = mid_calc;
        end
    end

    assign we    = cmd.wr_ins || cmd.wr_shift;
    assign waddr = cmd.wr_shift ? mid_reg : AW'(count_reg);
    assign wdata = cmd.wr_shift ? rdata : {nk, course_reg, year_reg};

    skat_ram #(
        .WIDTH(WW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_ins) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.dec_count) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_req_type;
            key_reg    <= KEY_BITS'(s_key);
            course_reg <= s_course_code;
            year_reg   <= s_year_code;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
        end else if (cmd.step) begin
            if (stat.key_lt) begin
                hi_reg <= CW'(mid_reg);
            end else begin
                lo_reg <= j_inc;
            end
        end
        if (cmd.rd_mid) begin
            mid_reg <= mid_calc;
        end else if (cmd.wr_shift) begin
            mid_reg <= AW'(j_inc);
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_sel)
                RS_INS: begin
                    res_key_reg    <= 16'(nk);
                    res_course_reg <= 2'd0;
                    res_year_reg   <= 2'd0;
                end
                RS_FOUND: begin
                    res_key_reg    <= 16'(rd_key);
                    res_course_reg <= rdata[3:2];
                    res_year_reg   <= rdata[1:0];
                end
                default: begin
                    res_key_reg    <= 16'd0;
                    res_course_reg <= 2'd0;
                    res_year_reg   <= 2'd0;
                end
            endcase
        end
    end

    // The result is registered in the cycle it is decided, so the output
    // stage takes it in the cycle after, together with the updated count.
    logic out_load_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_load_d_reg <= 1'b0;
        end else begin
            out_load_d_reg <= cmd.out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load_d_reg) begin
            m_status_reg <= res_status_reg;
            m_key_reg    <= res_key_reg;
            m_course_reg <= res_course_reg;
            m_year_reg   <= res_year_reg;
            m_fill_reg   <= 7'(count_reg);
        end
    end

    assign stat.req         = req_reg;
    assign stat.full        = (count_reg >= CW'(CAPACITY));
    assign stat.empty       = (count_reg == '0);
    assign stat.exhausted   = &rd_key;
    assign stat.range_empty = (lo_reg >= hi_reg);
    assign stat.key_eq      = (rd_key == key_reg);
    assign stat.key_lt      = (key_reg < rd_key);
    assign stat.shift_more  = (j_inc < count_reg);
    assign stat.out_free    = !m_valid_reg && !out_load_d_reg;

    assign m_valid         = m_valid_reg && !out_load_d_reg;
    assign m_status        = m_status_reg;
    assign m_result_key    = m_key_reg;
    assign m_result_course = m_course_reg;
    assign m_result_year   = m_year_reg;
    assign m_fill_count    = m_fill_reg;

endmodule

// ===== rtl/sorted_key_table_autoinc.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// request  | s_valid / s_ready  | s_req_type, s_key, s_course_code, s_year_code
// result   | m_valid / m_ready  | m_status, m_result_key, m_result_course,
//          |                    | m_result_year, m_fill_count
//
// One item is in flight at a time; each passes through a table memory with
// one read port, one write port and a registered read. Insert appends at
// the end, lookup is a binary search, and delete moves every later record
// down one slot after the search. Synchronous active-low reset empties the
// table at once; the memory itself is not cleared. A stalled result holds
// the next item at the request port.

module sorted_key_table_autoinc import skat_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_key,
    input  logic [1:0]  s_course_code,
    input  logic [1:0]  s_year_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_result_key,
    output logic [1:0]  m_result_course,
    output logic [1:0]  m_result_year,
    output logic [6:0]  m_fill_count
);

    cmd_t  cmd;
    stat_t stat;

    skat_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    skat_dp #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_req_type     (s_req_type),
        .s_key          (s_key),
        .s_course_code  (s_course_code),
        .s_year_code    (s_year_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_key   (m_result_key),
        .m_result_course(m_result_course),
        .m_result_year  (m_result_year),
        .m_fill_count   (m_fill_count),
        .cmd            (cmd),
        .stat           (stat)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another item is in progress");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_ins |-> !stat.full)
        else $error("insert written into a full table");

    a_failed_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_result_key == 16'd0))
        else $error("failed request returned a nonzero key");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_ins && cmd.wr_shift))
        else $error("insert and shift write in the same cycle");

endmodule

// ===== verif/sorted_key_table_autoinc_tb.sv =====
`timescale 1ns / 1ps

module sorted_key_table_autoinc_tb;
    import skat_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [15:0] KEY_MAX = 16'hFFFF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1330;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] key;
        logic [1:0]  course;
        logic [1:0]  year;
    } table_row_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] key;
        logic [1:0]  course;
        logic [1:0]  year;
        logic [6:0]  fill;
    } table_answer_t;

    class table_scoreboard;
        table_row_t rows[$];
        table_answer_t owed[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_request(logic [1:0] req, logic [15:0] key,
                                   logic [1:0] course, logic [1:0] year);
            table_row_t row;
            table_answer_t ans;
            int slot;
            ans = '0;
            slot = -1;
            foreach (rows[i]) begin
                if (rows[i].key == key) begin
                    slot = i;
                end
            end
            case (req)
                REQ_INSERT: begin
                    if (rows.size() >= TABLE_DEPTH) begin
                        ans.status = ST_FULL;
                    end else if (rows.size() > 0 && rows[rows.size() - 1].key == KEY_MAX) begin
                        ans.status = ST_KEYS_EXHAUSTED;
                    end else begin
                        row.key = (rows.size() == 0) ? 16'd1 : rows[rows.size() - 1].key + 16'd1;
                        row.course = course;
                        row.year = year;
                        rows.push_back(row);
                        ans.key = row.key;
                    end
                end
                REQ_LOOKUP: begin
                    if (slot < 0) begin
                        ans.status = ST_NOT_FOUND;
                    end else begin
                        ans.key = rows[slot].key;
                        ans.course = rows[slot].course;
                        ans.year = rows[slot].year;
                    end
                end
                REQ_DELETE: begin
                    if (slot < 0) begin
                        ans.status = ST_NOT_FOUND;
                    end else begin
                        rows.delete(slot);
                    end
                end
                default: begin
                end
            endcase
            ans.fill = 7'(rows.size());
            owed.push_back(ans);
        endfunction

        function void check_result(table_answer_t got);
            table_answer_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result with nothing outstanding: %p", got);
                end
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.key !== want.key ||
                got.course !== want.course || got.year !== want.year ||
                got.fill !== want.fill) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: status %0d/%0d key %0d/%0d course %0d/%0d",
                             $realtime, want.status, got.status, want.key, got.key,
                             want.course, got.course);
                    $display("    year %0d/%0d fill %0d/%0d (expected/actual)",
                             want.year, got.year, want.fill, got.fill);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [15:0] s_key = '0;
    logic [1:0]  s_course_code = '0;
    logic [1:0]  s_year_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_result_key;
    logic [1:0]  m_result_course;
    logic [1:0]  m_result_year;
    logic [6:0]  m_fill_count;

    bit brisk = 1'b0;
    bit hold_req = 1'b0;
    table_scoreboard sb;

    sorted_key_table_autoinc dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_key           (s_key),
        .s_course_code   (s_course_code),
        .s_year_code     (s_year_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_key    (m_result_key),
        .m_result_course (m_result_course),
        .m_result_year   (m_result_year),
        .m_fill_count    (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(30_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    // Handshake signals only change at rising edges, so the falling edge
    // sees exactly what the next rising edge will accept.
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && s_valid && s_ready) begin
                sb.note_request(s_req_type, s_key, s_course_code, s_year_code);
            end
            if (aresetn && m_valid && m_ready) begin
                sb.check_result({m_status, m_result_key, m_result_course,
                                 m_result_year, m_fill_count});
            end
        end
    end

    initial begin
        int pick;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (brisk) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 24)) @(posedge aclk);
                end else if (pick < 93) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(8, 50)) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [15:0] key,
                                input logic [1:0] course, input logic [1:0] year);
        bit taken;
        int gap;
        int pick;
        s_valid <= 1'b1;
        s_req_type <= req;
        s_key <= key;
        s_course_code <= course;
        s_year_code <= year;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        gap = 0;
        if (!brisk) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                gap = $urandom_range(10, 60);
            end else if (pick >= 40) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        int bias;
        int roll;
        int held;
        logic [1:0] req;
        logic [15:0] key;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Empty table, unused request, inserts with payload extremes,
        // hits and misses, deletes at the middle, end and front.
        send_request(REQ_LOOKUP, 16'd0, 2'd0, 2'd0);
        send_request(REQ_DELETE, KEY_MAX, 2'd3, 2'd2);
        send_request(REQ_UNUSED, KEY_MAX, 2'd3, 2'd2);
        send_request(REQ_INSERT, 16'd0, 2'd3, 2'd2);
        send_request(REQ_INSERT, KEY_MAX, 2'd0, 2'd0);
        send_request(REQ_INSERT, 16'h5A5A, 2'd1, 2'd1);
        send_request(REQ_INSERT, 16'hA5A5, 2'd2, 2'd2);
        send_request(REQ_LOOKUP, 16'd1, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd4, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd2, 2'd3, 2'd2);
        send_request(REQ_LOOKUP, 16'd0, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd5, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, KEY_MAX, 2'd0, 2'd0);
        send_request(REQ_DELETE, 16'd2, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd2, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd3, 2'd0, 2'd0);
        send_request(REQ_DELETE, 16'd4, 2'd0, 2'd0);
        send_request(REQ_INSERT, 16'd0, 2'd1, 2'd2);
        send_request(REQ_DELETE, 16'd1, 2'd0, 2'd0);
        send_request(REQ_DELETE, 16'd1, 2'd0, 2'd0);
        send_request(REQ_UNUSED, 16'd0, 2'd0, 2'd0);
        send_request(REQ_DELETE, 16'd3, 2'd0, 2'd0);
        send_request(REQ_DELETE, 16'd4, 2'd0, 2'd0);
        send_request(REQ_INSERT, 16'd0, 2'd2, 2'd1);

        bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: bias = 25;
                    1: bias = 50;
                    default: bias = 85;
                endcase
            end
            if (n == 600) begin
                hold_req = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                req = REQ_UNUSED;
            end else if (roll < bias) begin
                req = REQ_INSERT;
            end else begin
                req = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_DELETE;
            end
            held = sb.rows.size();
            if (held > 0 && $urandom_range(0, 9) < 7) begin
                key = sb.rows[$urandom_range(0, held - 1)].key;
            end else begin
                case ($urandom_range(0, 3))
                    0: key = 16'($urandom);
                    1: key = 16'd0;
                    2: key = KEY_MAX;
                    default: key = (held == 0) ? 16'd1 : sb.rows[held - 1].key + 16'd1;
                endcase
            end
            send_request(req, key, 2'($urandom), 2'($urandom_range(0, 2)));
        end

        // Trim the table to one record, fill it past capacity, then free
        // and refill a slot at the full mark.
        brisk = 1'b1;
        while (sb.rows.size() > 1) begin
            send_request(REQ_DELETE, sb.rows[sb.rows.size() - 1].key, 2'd0, 2'd0);
        end
        if (sb.rows.size() == 0) begin
            send_request(REQ_INSERT, 16'($urandom), 2'($urandom), 2'($urandom_range(0, 2)));
        end
        repeat (TABLE_DEPTH) begin
            send_request(REQ_INSERT, 16'($urandom), 2'($urandom), 2'($urandom_range(0, 2)));
        end
        send_request(REQ_DELETE, sb.rows[0].key, 2'd0, 2'd0);
        send_request(REQ_INSERT, 16'd0, 2'd3, 2'd2);
        send_request(REQ_INSERT, 16'd0, 2'd1, 2'd1);
        send_request(REQ_DELETE, sb.rows[0].key, 2'd0, 2'd0);
        send_request(REQ_INSERT, 16'd0, 2'd2, 2'd0);
        brisk = 1'b0;
        send_request(REQ_LOOKUP, KEY_MAX, 2'd0, 2'd0);
        send_request(REQ_LOOKUP, 16'd0, 2'd0, 2'd0);
        while (sb.rows.size() > 0) begin
            send_request(REQ_DELETE, sb.rows[$urandom_range(0, sb.rows.size() - 1)].key,
                         2'($urandom), 2'($urandom_range(0, 2)));
        end
        send_request(REQ_INSERT, 16'd0, 2'd0, 2'd1);
        s_valid <= 1'b0;

        while (sb.owed.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
